FILE: src/vhnn_pkg.sv
`default_nettype none
package vhnn_pkg;

  // table geometry
  localparam int TABLE_SETS      = 256;  // power of two
  localparam int TABLE_WAYS      = 4;
  localparam int MAX_POINTS      = 32;
  localparam int NEIGHBOR_RADIUS = 1;

  localparam int ENTRIES = TABLE_SETS * TABLE_WAYS;
  localparam int SET_W   = $clog2(TABLE_SETS);
  localparam int WAY_W   = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int EIDX_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PADDR_W = $clog2(ENTRIES * MAX_POINTS);

  // datapath widths
  localparam int COORD_W = 24;
  localparam int OFF_W   = 3;   // neighbour offset, -1..1
  localparam int NKEY_W  = 26;  // neighbour key, may leave the 24-bit range
  localparam int OP_W    = 25;  // coordinate difference
  localparam int PROD_W  = 2 * OP_W;
  localparam int SQ_W    = 49;  // magnitude of one square
  localparam int DIST_W  = 51;  // sum of three squares
  localparam int VS_W    = 16;
  localparam int PPV_W   = 6;
  localparam int MD_W    = 23;
  localparam int KEEP_W  = 21;
  localparam int CFG_W   = 23;
  localparam int LIM_W   = 7;

  localparam logic [7:0]  MARK_COLOUR    = 8'd255;
  localparam int          SCAN_AGE_LIMIT = 30;
  localparam logic [31:0] HASH_X = 32'd73856093;
  localparam logic [31:0] HASH_Y = 32'd19349669;
  localparam logic [31:0] HASH_Z = 32'd83492791;
  localparam logic [31:0] HASH_F = 32'd2654435761;

  typedef enum logic [1:0] {
    KIND_ADD, KIND_QUERY, KIND_PRUNE, KIND_NONE
  } kind_e;

  typedef enum logic [2:0] {
    STAT_ADDED, STAT_VOXEL_FULL, STAT_SET_FULL, STAT_MATCH, STAT_NO_MATCH, STAT_PRUNED
  } status_e;

  typedef enum logic [1:0] {
    CFG_VOXEL_SIZE, CFG_POINTS_PER_VOXEL, CFG_MATCH_DISTANCE, CFG_KEEP_DISTANCE
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_THR, S_NB, S_ERD, S_A_CHK, S_A_NEW,
    S_Q_CHK, S_Q_PRD, S_DIST, S_Q_EVAL, S_Q_FIN, S_P_ERD, S_P_CHK, S_P_EVAL, S_DONE
  } fsm_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic [7:0]                 color_a;
    logic [7:0]                 color_b;
    logic [7:0]                 color_c;
    logic [31:0]                scan_tag;
  } in_word_t;

  typedef struct packed {
    status_e                    status;
    logic signed [COORD_W-1:0]  match_x;
    logic signed [COORD_W-1:0]  match_y;
    logic signed [COORD_W-1:0]  match_z;
    logic [7:0]                 match_color_a;
    logic [7:0]                 match_color_b;
    logic [7:0]                 match_color_c;
    logic [31:0]                match_scan;
  } out_word_t;

  typedef struct packed {
    logic                       valid;
    logic                       marked;
    logic signed [COORD_W-1:0]  kx;
    logic signed [COORD_W-1:0]  ky;
    logic signed [COORD_W-1:0]  kz;
    logic [CNT_W-1:0]           count;
  } ent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [7:0]                 a;
    logic [7:0]                 b;
    logic [7:0]                 c;
    logic [31:0]                scan;
  } pt_t;

  // only the low SET_W bits of the wrapped products reach the set index
  function automatic logic [SET_W-1:0] set_of(input logic [COORD_W-1:0] kx,
                                              input logic [COORD_W-1:0] ky,
                                              input logic [COORD_W-1:0] kz,
                                              input logic flag);
    logic [SET_W-1:0] hx, hy, hz, hf;
    hx = kx[SET_W-1:0] * HASH_X[SET_W-1:0];
    hy = ky[SET_W-1:0] * HASH_Y[SET_W-1:0];
    hz = kz[SET_W-1:0] * HASH_Z[SET_W-1:0];
    hf = flag ? HASH_F[SET_W-1:0] : '0;
    return hx ^ hy ^ hz ^ hf;
  endfunction

endpackage
`default_nettype wire

FILE: src/vhnn_in_if.sv
`default_nettype none
interface vhnn_in_if import vhnn_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/vhnn_out_if.sv
`default_nettype none
interface vhnn_out_if import vhnn_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/vhnn_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle, then round half away from zero.
module vhnn_div import vhnn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [COORD_W-1:0] dividend_i,
  input  logic [VS_W-1:0]           divisor_i,
  output logic                      done_o,
  output logic signed [COORD_W-1:0] quot_o
);

  localparam int STEPS = COORD_W;
  localparam int SC_W  = $clog2(STEPS + 1);

  logic              busy_q, done_q;
  logic [SC_W-1:0]   cnt_q;
  logic              neg_q;
  logic [COORD_W-1:0] num_q;
  logic [VS_W-1:0]   rem_q, vs_q;
  logic signed [COORD_W-1:0] quot_q;

  logic [VS_W:0]     rsh, rdiff;
  logic              ge, up;
  logic [COORD_W:0]  qr, qs;
  logic [COORD_W-1:0] mag;

  assign rsh   = {rem_q, num_q[COORD_W-1]};
  assign ge    = rsh >= {1'b0, vs_q};
  assign rdiff = rsh - {1'b0, vs_q};
  assign up    = {rem_q, 1'b0} >= {1'b0, vs_q};
  assign qr    = {1'b0, num_q} + (COORD_W + 1)'(up);
  assign qs    = neg_q ? -qr : qr;
  assign mag   = dividend_i[COORD_W-1] ? COORD_W'(-dividend_i) : dividend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == SC_W'(STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= dividend_i[COORD_W-1];
      num_q <= mag;
      rem_q <= '0;
      vs_q  <= divisor_i;
    end else if (busy_q && cnt_q != SC_W'(STEPS)) begin
      num_q <= {num_q[COORD_W-2:0], ge};
      rem_q <= ge ? rdiff[VS_W-1:0] : rsh[VS_W-1:0];
    end else if (busy_q) begin
      quot_q <= qs[COORD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

FILE: src/voxel_hash_nearest_neighbor.sv
// Voxel hash nearest-neighbour store.
// in_i takes one word per command: add a point, query the nearest point, or
// prune the table. out_o gives one status word per add, query and prune; kind 3
// is swallowed with no result. Words move on valid && ready at the rising edge.
// cfg_we_i writes register cfg_idx_i from cfg_data_i; write only while idle.
// Items run one at a time; in_i.ready is high only while the sequencer idles.
// The key needs three rounding divides on the shared serial divider. Add then
// walks its set one way at a time. A query squares the match distance on the
// shared multiplier, then for each of the 27 neighbour voxels reads up to
// TABLE_WAYS entries and measures the distance to each stored point. Prune
// squares the prune radius, then walks all ENTRIES entries: a free one is
// skipped, a marked one is judged by its scan age, an unmarked one by distance.
// The finished word sits in an output register; the next item is taken while
// it waits, and the sequencer only holds at its end if the slot is still full.
// After reset the entry table is cleared, one entry a cycle, before in_i.ready
// rises. The config registers return to their reset values.
`default_nettype none
module voxel_hash_nearest_neighbor import vhnn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  vhnn_in_if.sink          in_i,
  vhnn_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // config
  logic [VS_W-1:0]   vsize_q;
  logic [PPV_W-1:0]  ppv_q;
  logic [MD_W-1:0]   md_q;
  logic [KEEP_W-1:0] keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsize_q <= VS_W'(1024);
      ppv_q   <= PPV_W'(20);
      md_q    <= MD_W'(1024);
      keep_q  <= KEEP_W'(102400);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VOXEL_SIZE:       vsize_q <= cfg_data_i[VS_W-1:0];
        CFG_POINTS_PER_VOXEL: ppv_q   <= cfg_data_i[PPV_W-1:0];
        CFG_MATCH_DISTANCE:   md_q    <= cfg_data_i[MD_W-1:0];
        CFG_KEEP_DISTANCE:    keep_q  <= cfg_data_i[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // memories: entry table and point slots, registered reads
  ent_t ent_mem [ENTRIES];
  pt_t  pt_mem  [ENTRIES * MAX_POINTS];

  logic               ent_we, ent_re, pt_we, pt_re;
  logic [EIDX_W-1:0]  ent_waddr, ent_raddr;
  logic [PADDR_W-1:0] pt_waddr, pt_raddr;
  ent_t               ent_wdata, ent_rd_q;
  pt_t                pt_wdata, pt_rd_q;

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rd_q <= pt_mem[pt_raddr];
  end

  function automatic logic [PADDR_W-1:0] pt_addr(input logic [EIDX_W-1:0] e,
                                                 input logic [CNT_W-1:0] s);
    return PADDR_W'(e) * PADDR_W'(MAX_POINTS) + PADDR_W'(s);
  endfunction

  // sequencer state
  fsm_e               state_q, state_d;
  logic [EIDX_W-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_load;
  out_word_t          out_q;

  in_word_t           item_q, item_d;
  logic               flag_q, flag_d;
  logic signed [COORD_W-1:0] kx_q, ky_q, kz_q, kx_d, ky_d, kz_d;
  logic [1:0]         didx_q, didx_d;
  logic [OFF_W-1:0]   offx_q, offy_q, offz_q, offx_d, offy_d, offz_d;
  logic [EIDX_W-1:0]  base_q, base_d, esel_q, esel_d, pe_q, pe_d;
  logic [WAY_W-1:0]   way_q, way_d, fway_q, fway_d;
  logic               ffound_q, ffound_d;
  logic [CNT_W-1:0]   npts_q, npts_d, pidx_q, pidx_d;
  logic [2:0]         dcnt_q, dcnt_d;
  logic signed [OP_W-1:0]   op_q, op_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [DIST_W-1:0]  acc_q, acc_d, thr_q, thr_d, best_q, best_d;
  logic               found_q, found_d;
  pt_t                bpt_q, bpt_d;
  status_e            res_q, res_d;

  // shared divider
  logic                      div_start, div_done;
  logic signed [COORD_W-1:0] div_num, div_quot;
  logic [VS_W-1:0]           vs_eff;

  assign vs_eff = (vsize_q == '0) ? VS_W'(1) : vsize_q;

  always_comb begin
    case (didx_q)
      2'd0:    div_num = item_q.point_x;
      2'd1:    div_num = item_q.point_y;
      default: div_num = item_q.point_z;
    endcase
  end

  vhnn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (vs_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // neighbour key, set index and entry match
  logic [NKEY_W-1:0] nkx, nky, nkz;
  logic [SET_W-1:0]  set_idx;
  logic              ent_hit, nb_last;
  logic [EIDX_W-1:0] ent_idx;

  assign nkx = {{(NKEY_W-COORD_W){kx_q[COORD_W-1]}}, kx_q}
             + {{(NKEY_W-OFF_W){offx_q[OFF_W-1]}}, offx_q};
  assign nky = {{(NKEY_W-COORD_W){ky_q[COORD_W-1]}}, ky_q}
             + {{(NKEY_W-OFF_W){offy_q[OFF_W-1]}}, offy_q};
  assign nkz = {{(NKEY_W-COORD_W){kz_q[COORD_W-1]}}, kz_q}
             + {{(NKEY_W-OFF_W){offz_q[OFF_W-1]}}, offz_q};
  assign set_idx = set_of(nkx[COORD_W-1:0], nky[COORD_W-1:0], nkz[COORD_W-1:0], flag_q);
  assign ent_idx = base_q + EIDX_W'(way_q);

  // out-of-range neighbour keys never equal a stored (24-bit) key
  assign ent_hit = ent_rd_q.valid && (ent_rd_q.marked == flag_q)
                && ({{(NKEY_W-COORD_W){ent_rd_q.kx[COORD_W-1]}}, ent_rd_q.kx} == nkx)
                && ({{(NKEY_W-COORD_W){ent_rd_q.ky[COORD_W-1]}}, ent_rd_q.ky} == nky)
                && ({{(NKEY_W-COORD_W){ent_rd_q.kz[COORD_W-1]}}, ent_rd_q.kz} == nkz);

  assign nb_last = (offx_q == OFF_W'(NEIGHBOR_RADIUS)) && (offy_q == OFF_W'(NEIGHBOR_RADIUS))
                && (offz_q == OFF_W'(NEIGHBOR_RADIUS));

  // misc derived values
  logic [LIM_W-1:0]  lim;
  logic [CNT_W-1:0]  ent_npts;
  logic [MD_W:0]     prune_r;
  logic signed [32:0] age;
  logic [SQ_W-1:0]   sq;
  logic              accept;

  assign lim      = ({1'b0, ppv_q} < LIM_W'(MAX_POINTS)) ? {1'b0, ppv_q} : LIM_W'(MAX_POINTS);
  assign ent_npts = (ent_rd_q.count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : ent_rd_q.count;
  assign prune_r  = {1'b0, keep_q, 2'b00} + (MD_W+1)'(keep_q);   // 5 * keep_distance
  assign age      = $signed({1'b0, item_q.scan_tag}) - $signed({1'b0, pt_rd_q.scan});
  assign sq       = prod_q[SQ_W-1:0];
  assign accept   = in_i.valid && in_i.ready;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    item_d   = item_q;
    flag_d   = flag_q;
    kx_d     = kx_q;
    ky_d     = ky_q;
    kz_d     = kz_q;
    didx_d   = didx_q;
    offx_d   = offx_q;
    offy_d   = offy_q;
    offz_d   = offz_q;
    base_d   = base_q;
    esel_d   = esel_q;
    pe_d     = pe_q;
    way_d    = way_q;
    fway_d   = fway_q;
    ffound_d = ffound_q;
    npts_d   = npts_q;
    pidx_d   = pidx_q;
    dcnt_d   = dcnt_q;
    op_d     = op_q;
    acc_d    = acc_q;
    thr_d    = thr_q;
    best_d   = best_q;
    found_d  = found_q;
    bpt_d    = bpt_q;
    res_d    = res_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = ent_idx;
    ent_wdata = ent_rd_q;
    ent_re    = 1'b0;
    ent_raddr = ent_idx;
    pt_we     = 1'b0;
    pt_waddr  = pt_addr(ent_idx, ent_rd_q.count);
    pt_wdata  = '{x: item_q.point_x, y: item_q.point_y, z: item_q.point_z,
                  a: item_q.color_a, b: item_q.color_b, c: item_q.color_c,
                  scan: item_q.scan_tag};
    pt_re     = 1'b0;
    pt_raddr  = pt_addr(esel_q, pidx_q);

    case (state_q)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == EIDX_W'(ENTRIES - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          item_d  = in_i.data;
          flag_d  = (in_i.data.color_a == MARK_COLOUR) || (in_i.data.color_c == MARK_COLOUR);
          didx_d  = 2'd0;
          dcnt_d  = '0;
          found_d = 1'b0;
          pe_d    = '0;
          case (in_i.data.kind)
            KIND_ADD: begin
              offx_d  = '0;
              offy_d  = '0;
              offz_d  = '0;
              state_d = S_DIV_GO;
            end
            KIND_QUERY: begin
              offx_d  = OFF_W'(-NEIGHBOR_RADIUS);
              offy_d  = OFF_W'(-NEIGHBOR_RADIUS);
              offz_d  = OFF_W'(-NEIGHBOR_RADIUS);
              state_d = S_DIV_GO;
            end
            KIND_PRUNE: state_d = S_THR;
            default:    state_d = S_IDLE;
          endcase
        end
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          case (didx_q)
            2'd0:    kx_d = div_quot;
            2'd1:    ky_d = div_quot;
            default: kz_d = div_quot;
          endcase
          if (didx_q == 2'd2) begin
            dcnt_d  = '0;
            state_d = (item_q.kind == KIND_ADD) ? S_NB : S_THR;
          end else begin
            didx_d  = didx_q + 1'b1;
            state_d = S_DIV_GO;
          end
        end
      end

      // square of the match distance or of the prune radius
      S_THR: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 3'd0) begin
          op_d = (item_q.kind == KIND_QUERY) ? OP_W'(md_q) : OP_W'(prune_r);
        end else if (dcnt_q == 3'd2) begin
          thr_d   = DIST_W'(sq);
          state_d = (item_q.kind == KIND_QUERY) ? S_NB : S_P_ERD;
        end
      end

      S_NB: begin
        base_d   = EIDX_W'(set_idx) * EIDX_W'(TABLE_WAYS);
        way_d    = '0;
        ffound_d = 1'b0;
        state_d  = S_ERD;
      end

      S_ERD: begin
        ent_re  = 1'b1;
        state_d = (item_q.kind == KIND_ADD) ? S_A_CHK : S_Q_CHK;
      end

      S_A_CHK: begin
        if (ent_hit) begin
          if ({1'b0, ent_rd_q.count} >= lim) begin
            res_d = STAT_VOXEL_FULL;
          end else begin
            pt_we           = 1'b1;
            ent_we          = 1'b1;
            ent_wdata.count = ent_rd_q.count + 1'b1;
            res_d           = STAT_ADDED;
          end
          state_d = S_DONE;
        end else begin
          if (!ent_rd_q.valid && !ffound_q) begin
            ffound_d = 1'b1;
            fway_d   = way_q;
          end
          if (way_q == WAY_W'(TABLE_WAYS - 1)) begin
            if (ffound_q || !ent_rd_q.valid) begin
              state_d = S_A_NEW;
            end else begin
              res_d   = STAT_SET_FULL;
              state_d = S_DONE;
            end
          end else begin
            way_d   = way_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end

      S_A_NEW: begin
        ent_we    = 1'b1;
        ent_waddr = base_q + EIDX_W'(fway_q);
        ent_wdata = '{valid: 1'b1, marked: flag_q, kx: kx_q, ky: ky_q, kz: kz_q,
                      count: CNT_W'(1)};
        pt_we     = 1'b1;
        pt_waddr  = pt_addr(base_q + EIDX_W'(fway_q), '0);
        res_d     = STAT_ADDED;
        state_d   = S_DONE;
      end

      S_Q_CHK: begin
        if (ent_hit && ent_npts != '0) begin
          esel_d  = ent_idx;
          npts_d  = ent_npts;
          pidx_d  = '0;
          state_d = S_Q_PRD;
        end else if (ent_hit || way_q == WAY_W'(TABLE_WAYS - 1)) begin
          state_d = S_Q_FIN;   // next neighbour, handled there
        end else begin
          way_d   = way_q + 1'b1;
          state_d = S_ERD;
        end
      end

      S_Q_PRD: begin
        pt_re   = 1'b1;
        dcnt_d  = '0;
        state_d = S_DIST;
      end

      // squared distance to the item point through the shared multiplier
      S_DIST: begin
        dcnt_d = dcnt_q + 1'b1;
        case (dcnt_q)
          3'd0: op_d = $signed({pt_rd_q.x[COORD_W-1], pt_rd_q.x})
                     - $signed({item_q.point_x[COORD_W-1], item_q.point_x});
          3'd1: op_d = $signed({pt_rd_q.y[COORD_W-1], pt_rd_q.y})
                     - $signed({item_q.point_y[COORD_W-1], item_q.point_y});
          3'd2: begin
            op_d  = $signed({pt_rd_q.z[COORD_W-1], pt_rd_q.z})
                  - $signed({item_q.point_z[COORD_W-1], item_q.point_z});
            acc_d = DIST_W'(sq);
          end
          3'd3: acc_d = acc_q + DIST_W'(sq);
          default: begin
            acc_d   = acc_q + DIST_W'(sq);
            state_d = (item_q.kind == KIND_QUERY) ? S_Q_EVAL : S_P_EVAL;
          end
        endcase
      end

      S_Q_EVAL: begin
        if (!found_q || acc_q < best_q) begin
          found_d = 1'b1;
          best_d  = acc_q;
          bpt_d   = pt_rd_q;
        end
        if (CNT_W'(pidx_q + 1'b1) == npts_q) begin
          state_d = S_Q_FIN;
        end else begin
          pidx_d  = pidx_q + 1'b1;
          state_d = S_Q_PRD;
        end
      end

      // step to the next neighbour voxel, z fastest, or finish
      S_Q_FIN: begin
        if (nb_last) begin
          res_d   = (found_q && best_q < thr_q) ? STAT_MATCH : STAT_NO_MATCH;
          state_d = S_DONE;
        end else begin
          state_d = S_NB;
          if (offz_q != OFF_W'(NEIGHBOR_RADIUS)) begin
            offz_d = offz_q + 1'b1;
          end else begin
            offz_d = OFF_W'(-NEIGHBOR_RADIUS);
            if (offy_q != OFF_W'(NEIGHBOR_RADIUS)) begin
              offy_d = offy_q + 1'b1;
            end else begin
              offy_d = OFF_W'(-NEIGHBOR_RADIUS);
              offx_d = offx_q + 1'b1;
            end
          end
        end
      end

      S_P_ERD: begin
        ent_re    = 1'b1;
        ent_raddr = pe_q;
        state_d   = S_P_CHK;
      end

      S_P_CHK: begin
        if (!ent_rd_q.valid) begin
          pe_d = pe_q + 1'b1;
          if (pe_q == EIDX_W'(ENTRIES - 1)) begin
            res_d   = STAT_PRUNED;
            state_d = S_DONE;
          end else begin
            state_d = S_P_ERD;
          end
        end else begin
          pt_re    = 1'b1;
          pt_raddr = pt_addr(pe_q, '0);
          dcnt_d   = '0;
          state_d  = ent_rd_q.marked ? S_P_EVAL : S_DIST;
        end
      end

      S_P_EVAL: begin
        if (ent_rd_q.marked ? (age > 33'sd30) : (acc_q > thr_q)) begin
          ent_we          = 1'b1;
          ent_waddr       = pe_q;
          ent_wdata.valid = 1'b0;
        end
        pe_d = pe_q + 1'b1;
        if (pe_q == EIDX_W'(ENTRIES - 1)) begin
          res_d   = STAT_PRUNED;
          state_d = S_DONE;
        end else begin
          state_d = S_P_ERD;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    flag_q   <= flag_d;
    kx_q     <= kx_d;
    ky_q     <= ky_d;
    kz_q     <= kz_d;
    didx_q   <= didx_d;
    offx_q   <= offx_d;
    offy_q   <= offy_d;
    offz_q   <= offz_d;
    base_q   <= base_d;
    esel_q   <= esel_d;
    pe_q     <= pe_d;
    way_q    <= way_d;
    fway_q   <= fway_d;
    ffound_q <= ffound_d;
    npts_q   <= npts_d;
    pidx_q   <= pidx_d;
    dcnt_q   <= dcnt_d;
    op_q     <= op_d;
    prod_q   <= op_q * op_q;
    acc_q    <= acc_d;
    thr_q    <= thr_d;
    best_q   <= best_d;
    found_q  <= found_d;
    bpt_q    <= bpt_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q.status <= res_q;
      if (res_q == STAT_MATCH) begin
        out_q.match_x       <= bpt_q.x;
        out_q.match_y       <= bpt_q.y;
        out_q.match_z       <= bpt_q.z;
        out_q.match_color_a <= bpt_q.a;
        out_q.match_color_b <= bpt_q.b;
        out_q.match_color_c <= bpt_q.c;
        out_q.match_scan    <= bpt_q.scan;
      end else begin
        out_q.match_x       <= '0;
        out_q.match_y       <= '0;
        out_q.match_z       <= '0;
        out_q.match_color_a <= '0;
        out_q.match_color_b <= '0;
        out_q.match_color_c <= '0;
        out_q.match_scan    <= '0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

FILE: tb/voxel_hash_nearest_neighbor_test.sv
`timescale 1ns / 100ps
module voxel_hash_nearest_neighbor_test;
  import vhnn_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  vhnn_in_if  in_ch ();
  vhnn_out_if out_ch ();

  voxel_hash_nearest_neighbor dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block's registers and voxel table
  int unsigned sh_vs, sh_ppv, sh_md, sh_kd;
  bit vox_live [ENTRIES];
  bit vox_mark [ENTRIES];
  int vox_kx [ENTRIES];
  int vox_ky [ENTRIES];
  int vox_kz [ENTRIES];
  int unsigned vox_n [ENTRIES];
  int pt_x [ENTRIES*MAX_POINTS];
  int pt_y [ENTRIES*MAX_POINTS];
  int pt_z [ENTRIES*MAX_POINTS];
  logic [7:0] pt_a [ENTRIES*MAX_POINTS];
  logic [7:0] pt_b [ENTRIES*MAX_POINTS];
  logic [7:0] pt_c [ENTRIES*MAX_POINTS];
  logic [31:0] pt_scan [ENTRIES*MAX_POINTS];

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int  accepted = 0;
  bit  failed = 1'b0;
  bit  hold_rx = 1'b0;

  function automatic int round_key(int x, int unsigned v);
    longint ax, q, r;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    q = ax / v;
    r = ax % v;
    if (2 * r >= v) q++;
    return (x < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic int unsigned voxel_set(int kx, int ky, int kz, bit flag);
    logic [31:0] h, ux, uy, uz;
    ux = {8'd0, kx[23:0]};
    uy = {8'd0, ky[23:0]};
    uz = {8'd0, kz[23:0]};
    h = (ux * HASH_X) ^ (uy * HASH_Y) ^ (uz * HASH_Z) ^ (flag ? HASH_F : 32'd0);
    return h % TABLE_SETS;
  endfunction

  function automatic int find_voxel(int kx, int ky, int kz, bit flag);
    int base;
    base = voxel_set(kx, ky, kz, flag) * TABLE_WAYS;
    for (int w = 0; w < TABLE_WAYS; w++)
      if (vox_live[base+w] && vox_mark[base+w] == flag && vox_kx[base+w] == kx &&
          vox_ky[base+w] == ky && vox_kz[base+w] == kz)
        return base + w;
    return -1;
  endfunction

  function automatic longint unsigned dist2(int s, int x, int y, int z);
    longint dx, dy, dz;
    dx = longint'(pt_x[s]) - x;
    dy = longint'(pt_y[s]) - y;
    dz = longint'(pt_z[s]) - z;
    return dx*dx + dy*dy + dz*dz;
  endfunction

  function automatic void keep_point(int s, in_word_t w);
    pt_x[s] = int'(w.point_x);
    pt_y[s] = int'(w.point_y);
    pt_z[s] = int'(w.point_z);
    pt_a[s] = w.color_a;
    pt_b[s] = w.color_b;
    pt_c[s] = w.color_c;
    pt_scan[s] = w.scan_tag;
  endfunction

  // apply one command word to the shadow table; returns 0 when no word results
  function automatic bit apply_command(in_word_t w, output out_word_t r);
    int x, y, z, kx, ky, kz, e, base, best_slot, lim, n;
    int unsigned vs;
    bit flag, found;
    longint unsigned best, d, rr;
    longint md;
    x = int'(w.point_x);
    y = int'(w.point_y);
    z = int'(w.point_z);
    flag = (w.color_a == MARK_COLOUR) || (w.color_c == MARK_COLOUR);
    vs = (sh_vs == 0) ? 1 : sh_vs;
    r = '0;
    if (w.kind == KIND_NONE) return 1'b0;
    kx = round_key(x, vs);
    ky = round_key(y, vs);
    kz = round_key(z, vs);
    case (w.kind)
      KIND_ADD: begin
        e = find_voxel(kx, ky, kz, flag);
        if (e >= 0) begin
          lim = (sh_ppv < MAX_POINTS) ? sh_ppv : MAX_POINTS;
          if (vox_n[e] >= lim) begin
            r.status = STAT_VOXEL_FULL;
          end else begin
            keep_point(e*MAX_POINTS + vox_n[e], w);
            vox_n[e]++;
            r.status = STAT_ADDED;
          end
        end else begin
          r.status = STAT_SET_FULL;
          base = voxel_set(kx, ky, kz, flag) * TABLE_WAYS;
          for (int f = base; f < base + TABLE_WAYS; f++)
            if (!vox_live[f] && r.status == STAT_SET_FULL) begin
              vox_live[f] = 1'b1;
              vox_mark[f] = flag;
              vox_kx[f] = kx;
              vox_ky[f] = ky;
              vox_kz[f] = kz;
              vox_n[f] = 1;
              keep_point(f*MAX_POINTS, w);
              r.status = STAT_ADDED;
            end
        end
      end
      KIND_QUERY: begin
        found = 1'b0;
        best = 0;
        best_slot = 0;
        for (int i = kx - NEIGHBOR_RADIUS; i <= kx + NEIGHBOR_RADIUS; i++)
          for (int j = ky - NEIGHBOR_RADIUS; j <= ky + NEIGHBOR_RADIUS; j++)
            for (int k = kz - NEIGHBOR_RADIUS; k <= kz + NEIGHBOR_RADIUS; k++) begin
              e = find_voxel(i, j, k, flag);
              if (e >= 0) begin
                n = (vox_n[e] > MAX_POINTS) ? MAX_POINTS : vox_n[e];
                for (int p = 0; p < n; p++) begin
                  d = dist2(e*MAX_POINTS + p, x, y, z);
                  if (!found || d < best) begin
                    found = 1'b1;
                    best = d;
                    best_slot = e*MAX_POINTS + p;
                  end
                end
              end
            end
        md = sh_md;
        if (!found || best >= longint'(md*md)) begin
          r.status = STAT_NO_MATCH;
        end else begin
          r.status = STAT_MATCH;
          r.match_x = pt_x[best_slot][23:0];
          r.match_y = pt_y[best_slot][23:0];
          r.match_z = pt_z[best_slot][23:0];
          r.match_color_a = pt_a[best_slot];
          r.match_color_b = pt_b[best_slot];
          r.match_color_c = pt_c[best_slot];
          r.match_scan = pt_scan[best_slot];
        end
      end
      default: begin
        rr = 5 * longint'(sh_kd);
        rr = rr * rr;
        for (int en = 0; en < ENTRIES; en++)
          if (vox_live[en]) begin
            if (vox_mark[en]) begin
              if (longint'(w.scan_tag) - longint'(pt_scan[en*MAX_POINTS]) > SCAN_AGE_LIMIT)
                vox_live[en] = 1'b0;
            end else if (dist2(en*MAX_POINTS, x, y, z) > rr) begin
              vox_live[en] = 1'b0;
            end
          end
        r.status = STAT_PRUNED;
      end
    endcase
    return 1'b1;
  endfunction

  // long stretch with no idling on either side
  function automatic bit may_idle();
    return !(accepted >= 500 && accepted < 650) && ($urandom_range(99) < 16);
  endfunction

  // driver: accept, predict, then load the next word
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t r;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted++;
        if (apply_command(in_ch.data, r)) expected_words = {expected_words, r};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && !may_idle()) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_words.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result word: expected none actual %h", $time,
                   out_ch.data);
          failed = 1'b1;
        end else begin
          e = expected_words.pop_front();
          check_field("status", e.status, out_ch.data.status);
          check_field("match_x", e.match_x, out_ch.data.match_x);
          check_field("match_y", e.match_y, out_ch.data.match_y);
          check_field("match_z", e.match_z, out_ch.data.match_z);
          check_field("match_color_a", e.match_color_a, out_ch.data.match_color_a);
          check_field("match_color_b", e.match_color_b, out_ch.data.match_color_b);
          check_field("match_color_c", e.match_color_c, out_ch.data.match_color_c);
          check_field("match_scan", e.match_scan, out_ch.data.match_scan);
        end
      end
      out_ch.ready <= !hold_rx && !may_idle();
    end
  end

  // long receiver hold-off so the output slot fills and input stalls
  initial begin
    wait (accepted >= 300);
    @(negedge clk_i) hold_rx = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_word(kind_e k, int x, int y, int z, int a, int b, int c,
                           logic [31:0] scan);
    in_word_t w;
    w.kind = k;
    w.point_x = x[23:0];
    w.point_y = y[23:0];
    w.point_z = z[23:0];
    w.color_a = a[7:0];
    w.color_b = b[7:0];
    w.color_c = c[7:0];
    w.scan_tag = scan;
    pending_words = {pending_words, w};
  endtask

  // wait until every word is through, plus slack for a swallowed kind 3
  task automatic drain();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_ch.valid || expected_words.size() != 0);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v[CFG_W-1:0];
    case (idx)
      CFG_VOXEL_SIZE:       sh_vs = v & 16'hFFFF;
      CFG_POINTS_PER_VOXEL: sh_ppv = v & 6'h3F;
      CFG_MATCH_DISTANCE:   sh_md = v & 23'h7FFFFF;
      default:              sh_kd = v & 21'h1FFFFF;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int unsigned vs, int unsigned ppv, int unsigned md,
                          int unsigned kd);
    write_reg(CFG_VOXEL_SIZE, vs);
    write_reg(CFG_POINTS_PER_VOXEL, ppv);
    write_reg(CFG_MATCH_DISTANCE, md);
    write_reg(CFG_KEEP_DISTANCE, kd);
  endtask

  // mostly clustered points near the origin so queries meet stored points
  task automatic push_random(int unsigned scan_base);
    int k, span, x, y, z, a, c;
    logic [31:0] scan;
    k = $urandom_range(99);
    span = ((sh_vs == 0 ? 1 : sh_vs) * 4 > 8000000) ? 8000000 : (sh_vs == 0 ? 1 : sh_vs) * 4;
    if ($urandom_range(99) < 85) begin
      x = $urandom_range(2*span) - span;
      y = $urandom_range(2*span) - span;
      z = $urandom_range(2*span) - span;
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      x = (x << 8) >>> 8;
      y = (y << 8) >>> 8;
      z = (z << 8) >>> 8;
    end
    a = $urandom_range(255);
    c = $urandom_range(255);
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1)) a = 255;
      else c = 255;
    end
    scan = ($urandom_range(9) == 0) ? $urandom : scan_base + $urandom_range(60);
    if (k < 52)      push_word(KIND_ADD, x, y, z, a, $urandom_range(255), c, scan);
    else if (k < 95) push_word(KIND_QUERY, x, y, z, a, $urandom_range(255), c, scan);
    else if (k < 98) push_word(KIND_PRUNE, x, y, z, a, $urandom_range(255), c, scan);
    else             push_word(KIND_NONE, x, y, z, a, $urandom_range(255), c, scan);
  endtask

  initial begin
    int unsigned vs_l[6]  = '{1024, 0, 1, 65535, 512, 1024};
    int unsigned ppv_l[6] = '{2, 1, 63, 32, 8, 20};
    int unsigned md_l[6]  = '{1024, 0, 8388607, 1024, 3000, 1024};
    int unsigned kd_l[6]  = '{102400, 0, 1677721, 0, 20000, 102400};
    int same_set[$];
    int s0;
    sh_vs = 1024;
    sh_ppv = 20;
    sh_md = 1024;
    sh_kd = 102400;
    foreach (vox_live[i]) vox_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, marked points, tie, empty neighbourhood, full set
    push_word(KIND_ADD, 0, 0, 0, 1, 2, 3, 1);
    push_word(KIND_ADD, 100, 0, 0, 4, 5, 6, 2);
    push_word(KIND_QUERY, 50, 0, 0, 0, 0, 0, 0);        // tie, earlier kept
    push_word(KIND_ADD, 8388607, 8388607, 8388607, 255, 255, 0, 1);
    push_word(KIND_ADD, -8388608, -8388608, -8388608, 0, 0, 255, 32'hFFFFFFFF);
    push_word(KIND_QUERY, 8388607, 8388607, 8388600, 255, 0, 0, 0);
    push_word(KIND_QUERY, -8388608, -8388608, -8388608, 0, 0, 255, 0);
    push_word(KIND_QUERY, 8388607, 8388607, 8388607, 0, 0, 0, 0); // nothing unmarked
    push_word(KIND_QUERY, 5000, 5000, 5000, 0, 0, 0, 0);
    s0 = voxel_set(200, 0, 0, 1'b0);
    for (int kx = 200; kx < 8000 && same_set.size() < TABLE_WAYS + 1; kx++)
      if (voxel_set(kx, 0, 0, 1'b0) == s0) same_set = {same_set, kx};
    foreach (same_set[i]) push_word(KIND_ADD, same_set[i] * 1024, 0, 0, 7, 8, 9, 3);
    push_word(KIND_NONE, 1, 2, 3, 4, 5, 6, 7);
    push_word(KIND_ADD, 3000, 3000, 3000, 255, 1, 1, 100);
    push_word(KIND_PRUNE, 0, 0, 0, 0, 0, 0, 40);        // old marked and far voxels go
    push_word(KIND_PRUNE, 0, 0, 0, 0, 0, 0, 0);         // negative age keeps marked
    push_word(KIND_QUERY, 3000, 3000, 3000, 1, 0, 255, 0);
    push_word(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_regs(vs_l[ph], ppv_l[ph], md_l[ph], kd_l[ph]);
      if (ph == 0) begin
        // the same voxel three times with room for two
        for (int i = 0; i < 3; i++) push_word(KIND_ADD, 10240 + i, 0, 0, 0, 0, 0, i);
      end
      for (int i = 0; i < 165; i++) push_random(ph * 50);
      drain();
    end

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/vhnn_pkg.sv
src/vhnn_in_if.sv
src/vhnn_out_if.sv
src/vhnn_div.sv
src/voxel_hash_nearest_neighbor.sv
tb/voxel_hash_nearest_neighbor_test.sv
